>>> design/sha1_hash_engine_core_assert.svh
// Assertion helpers for the SHA-1 engine; clock i_clk, reset i_rst_n (active low).
`ifndef SHA1_HASH_ENGINE_CORE_ASSERT_SVH
`define SHA1_HASH_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication.
`define SHA1E_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SHA1E_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/sha1e_pkg.sv
package sha1e_pkg;

    localparam int LEN_BITS_DEFAULT = 64;
    localparam int BLK_WORDS        = 16;
    localparam int ROUNDS           = 80;
    localparam int CHAIN_WORDS      = 5;

    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    localparam logic [31:0] IV_0 = 32'h67452301;
    localparam logic [31:0] IV_1 = 32'hEFCDAB89;
    localparam logic [31:0] IV_2 = 32'h98BADCFE;
    localparam logic [31:0] IV_3 = 32'h10325476;
    localparam logic [31:0] IV_4 = 32'hC3D2E1F0;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [3:0] LEN_HI_ADDR = 4'd14;
    localparam logic [3:0] LEN_LO_ADDR = 4'd15;
    localparam logic [2:0] LAST_IDX    = 3'(CHAIN_WORDS - 1);

    // index 0 holds word a / H0
    typedef logic [CHAIN_WORDS-1:0][31:0] t_chain;

    localparam t_chain CHAIN_IV = {IV_4, IV_3, IV_2, IV_1, IV_0};

    typedef struct packed {
        logic        en;
        logic [3:0]  addr;
        logic [31:0] data;
    } t_mem_wr;

    typedef struct packed {
        logic [3:0] addr_a;
        logic [3:0] addr_b;
    } t_mem_rd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_PAD,
        ST_ZERO,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        RP_IDLE,
        RP_MIX,
        RP_USE
    } t_rphase;

    // Big-endian byte placement within a word; position 0 starts a fresh word.
    function automatic logic [31:0] merge_byte(input logic [31:0] acc,
                                               input logic [7:0]  b,
                                               input logic [1:0]  pos);
        logic [31:0] res;
        case (pos)
            2'd0:    res = {b, 24'h000000};
            2'd1:    res = {acc[31:24], b, 16'h0000};
            2'd2:    res = {acc[31:16], b, 8'h00};
            default: res = {acc[31:8], b};
        endcase
        return res;
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] r);
        logic [31:0] k;
        if (r < 7'd20)      k = K_R0;
        else if (r < 7'd40) k = K_R1;
        else if (r < 7'd60) k = K_R2;
        else                k = K_R3;
        return k;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0]  r,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
        logic [31:0] f;
        if (r < 7'd20)      f = (b & c) | (~b & d);
        else if (r < 7'd40) f = b ^ c ^ d;
        else if (r < 7'd60) f = (b & c) | (b & d) | (c & d);
        else                f = b ^ c ^ d;
        return f;
    endfunction

endpackage

>>> design/sha1e_mem.sv
module sha1e_mem (
    input  logic              i_clk,
    input  sha1e_pkg::t_mem_wr i_wr,
    input  sha1e_pkg::t_mem_rd i_rd,
    output logic [31:0]       o_rd_a,
    output logic [31:0]       o_rd_b
);
    import sha1e_pkg::*;

    logic [31:0] mem [BLK_WORDS];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_a <= mem[i_rd.addr_a];
        o_rd_b <= mem[i_rd.addr_b];
    end

endmodule

>>> design/sha1e_round.sv
module sha1e_round (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  sha1e_pkg::t_chain  i_h,
    output sha1e_pkg::t_mem_rd o_rd,
    input  logic [31:0]        i_rd_a,
    input  logic [31:0]        i_rd_b,
    output sha1e_pkg::t_mem_wr o_wr,
    output logic               o_done,
    output sha1e_pkg::t_chain  o_work
);
    import sha1e_pkg::*;

    t_rphase     r_phase, n_phase;
    logic [6:0]  r_round, n_round;
    t_chain      r_w, n_w;
    logic [31:0] r_x;
    logic        r_done;

    logic [6:0]  nr;
    logic        last_round;
    logic [31:0] sched_x;
    logic [31:0] w_cur;
    logic [31:0] t_sum;

    assign nr         = r_round + 7'd1;
    assign last_round = (r_round == 7'(ROUNDS - 1));
    assign sched_x    = r_x ^ i_rd_a ^ i_rd_b;
    // first sixteen rounds take the block word as stored; later ones expand in place
    assign w_cur      = (r_round < 7'(BLK_WORDS)) ? i_rd_a : {sched_x[30:0], sched_x[31]};
    assign t_sum      = {r_w[0][26:0], r_w[0][31:27]}
                      + round_f(r_round, r_w[1], r_w[2], r_w[3])
                      + r_w[4] + round_k(r_round) + w_cur;

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            RP_IDLE: begin
                if (i_start) n_phase = RP_USE;
            end
            RP_USE: begin
                if (last_round)                n_phase = RP_IDLE;
                else if (nr < 7'(BLK_WORDS))   n_phase = RP_USE;
                else                           n_phase = RP_MIX;
            end
            RP_MIX:  n_phase = RP_USE;
            default: n_phase = RP_IDLE;
        endcase
    end

    always_comb begin
        o_rd    = '0;
        o_wr    = '0;
        n_round = r_round;
        n_w     = r_w;
        case (r_phase)
            RP_IDLE: begin
                if (i_start) begin
                    o_rd.addr_a = 4'd0;
                    n_round     = 7'd0;
                    n_w         = i_h;
                end
            end
            RP_USE: begin
                n_w[0] = t_sum;
                n_w[1] = r_w[0];
                n_w[2] = {r_w[1][1:0], r_w[1][31:2]};
                n_w[3] = r_w[2];
                n_w[4] = r_w[3];
                if (r_round >= 7'(BLK_WORDS)) begin
                    o_wr.en   = 1'b1;
                    o_wr.addr = r_round[3:0];
                    o_wr.data = w_cur;
                end
                if (!last_round) begin
                    n_round = nr;
                    if (nr < 7'(BLK_WORDS)) begin
                        o_rd.addr_a = nr[3:0];
                    end else begin
                        o_rd.addr_a = nr[3:0] - 4'd3;
                        o_rd.addr_b = nr[3:0] - 4'd8;
                    end
                end
            end
            RP_MIX: begin
                // w[r-14] and w[r-16]; the latter shares the slot about to be rewritten
                o_rd.addr_a = r_round[3:0] + 4'd2;
                o_rd.addr_b = r_round[3:0];
            end
            default: begin
                o_rd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= RP_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= (r_phase == RP_USE) && last_round;
        end
    end

    always_ff @(posedge i_clk) begin
        r_round <= n_round;
        r_w     <= n_w;
        if (r_phase == RP_MIX) begin
            r_x <= i_rd_a ^ i_rd_b;
        end
    end

    assign o_done = r_done;
    assign o_work = r_w;

endmodule

>>> design/sha1_hash_engine_core.sv
// channel  | valid       | ready       | payload
// ---------+-------------+-------------+------------------------------------------
// in       | i_in_valid  | o_in_ready  | i_data_byte, i_byte_valid, i_last
// out      | o_out_valid | i_out_ready | o_digest_word, o_word_index, o_last_word
//
// A byte that does not close a block or end the message leaves input ready for the next item.
// The 64th byte of a block starts a compression: rounds 0-15 use the stored block words directly,
// rounds 16-79 each add a read phase first (four schedule words through two read ports), and
// the sum is then folded into the chaining value. A last item adds padding writes and one or
// two compressions, then five digest transactions; input is held off until the fifth is taken.
// Reset is synchronous and restores the initial chaining value with empty counters.

`include "sha1_hash_engine_core_assert.svh"

module sha1_hash_engine_core #(
    parameter int LENGTH_COUNTER_BITS = sha1e_pkg::LEN_BITS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sha1e_pkg::*;

    localparam int CNT_W = LENGTH_COUNTER_BITS - 3;

    t_state             r_state, n_state;
    t_state             r_ret, n_ret;
    t_chain             r_h, n_h;
    logic [5:0]         r_fill, n_fill;
    logic [CNT_W-1:0]   r_total, n_total;
    logic [31:0]        r_acc, n_acc;
    logic [4:0]         r_ptr, n_ptr;
    logic               r_two, n_two;
    logic [2:0]         r_oidx, n_oidx;

    logic     in_fire, out_fire;
    logic     start;
    t_mem_wr  top_wr, rnd_wr, mem_wr;
    t_mem_rd  rd;
    logic [31:0] rd_a, rd_b;
    logic     rnd_done;
    t_chain   work;
    logic [63:0] bits64;
    logic [4:0]  zero_lim;
    logic [31:0] word_in, word_pad;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = o_out_valid && i_out_ready;
    assign bits64   = 64'({r_total, 3'b000});
    // with the length spilling into a second block, clear the whole first one
    assign zero_lim = r_two ? 5'(BLK_WORDS) : {1'b0, LEN_HI_ADDR};
    assign word_in  = merge_byte(r_acc, i_data_byte, r_fill[1:0]);
    assign word_pad = merge_byte(r_acc, PAD_BYTE, r_fill[1:0]);
    assign mem_wr   = (r_state == ST_HASH) ? rnd_wr : top_wr;

    sha1e_mem u_mem (
        .i_clk  (i_clk),
        .i_wr   (mem_wr),
        .i_rd   (rd),
        .o_rd_a (rd_a),
        .o_rd_b (rd_b)
    );

    sha1e_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_h     (r_h),
        .o_rd    (rd),
        .i_rd_a  (rd_a),
        .i_rd_b  (rd_b),
        .o_wr    (rnd_wr),
        .o_done  (rnd_done),
        .o_work  (work)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_byte_valid && (r_fill == 6'd63)) n_state = ST_HASH;
                    else if (i_last)                      n_state = ST_PAD;
                end
            end
            ST_HASH: begin
                if (rnd_done) n_state = r_ret;
            end
            ST_PAD:  n_state = ST_ZERO;
            ST_ZERO: begin
                if (r_ptr >= zero_lim) n_state = r_two ? ST_HASH : ST_LEN_HI;
            end
            ST_LEN_HI: n_state = ST_LEN_LO;
            ST_LEN_LO: n_state = ST_HASH;
            ST_OUT: begin
                if (out_fire && (r_oidx == LAST_IDX)) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_ret   = r_ret;
        n_h     = r_h;
        n_fill  = r_fill;
        n_total = r_total;
        n_acc   = r_acc;
        n_ptr   = r_ptr;
        n_two   = r_two;
        n_oidx  = r_oidx;
        top_wr  = '0;
        start   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_fire && i_byte_valid) begin
                    top_wr  = '{en: 1'b1, addr: r_fill[5:2], data: word_in};
                    n_acc   = word_in;
                    n_fill  = r_fill + 6'd1;
                    n_total = r_total + CNT_W'(1);
                    if (r_fill == 6'd63) begin
                        start = 1'b1;
                        n_ret = i_last ? ST_PAD : ST_IDLE;
                    end
                end
            end
            ST_HASH: begin
                if (rnd_done) begin
                    for (int i = 0; i < CHAIN_WORDS; i++) begin
                        n_h[i] = r_h[i] + work[i];
                    end
                end
            end
            ST_PAD: begin
                top_wr = '{en: 1'b1, addr: r_fill[5:2], data: word_pad};
                n_ptr  = {1'b0, r_fill[5:2]} + 5'd1;
                n_two  = (r_fill >= 6'd56);
            end
            ST_ZERO: begin
                if (r_ptr < zero_lim) begin
                    top_wr = '{en: 1'b1, addr: r_ptr[3:0], data: 32'h0};
                    n_ptr  = r_ptr + 5'd1;
                end else if (r_two) begin
                    start = 1'b1;
                    n_ret = ST_ZERO;
                    n_two = 1'b0;
                    n_ptr = 5'd0;
                end
            end
            ST_LEN_HI: begin
                top_wr = '{en: 1'b1, addr: LEN_HI_ADDR, data: bits64[63:32]};
            end
            ST_LEN_LO: begin
                top_wr = '{en: 1'b1, addr: LEN_LO_ADDR, data: bits64[31:0]};
                start  = 1'b1;
                n_ret  = ST_OUT;
            end
            ST_OUT: begin
                if (out_fire) begin
                    if (r_oidx == LAST_IDX) begin
                        n_h     = CHAIN_IV;
                        n_fill  = 6'd0;
                        n_total = '0;
                        n_oidx  = 3'd0;
                    end else begin
                        n_oidx = r_oidx + 3'd1;
                    end
                end
            end
            default: begin
                top_wr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_h     <= CHAIN_IV;
            r_fill  <= 6'd0;
            r_total <= '0;
            r_ptr   <= 5'd0;
            r_two   <= 1'b0;
            r_oidx  <= 3'd0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_h     <= n_h;
            r_fill  <= n_fill;
            r_total <= n_total;
            r_ptr   <= n_ptr;
            r_two   <= n_two;
            r_oidx  <= n_oidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_out_valid   = (r_state == ST_OUT);
    assign o_digest_word = r_h[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == LAST_IDX);

    `SHA1E_ASSERT_NOW(a_done_in_hash, rnd_done, r_state == ST_HASH,
        "round unit finished outside a hash pass")
    `SHA1E_ASSERT_NOW(a_no_wr_clash, r_state == ST_HASH, !top_wr.en,
        "block memory written by control during compression")
    `SHA1E_ASSERT_NEXT(a_msg_restart, out_fire && o_last_word,
        r_state == ST_IDLE && r_fill == 6'd0 && r_h == CHAIN_IV,
        "engine not back to initial state after digest")
    `SHA1E_ASSERT_NOW(a_out_index, o_out_valid, r_oidx <= LAST_IDX,
        "digest word index out of range")

endmodule

>>> sim/sha1_digest_checker.sv
`timescale 1ns / 100ps

module sha1_digest_checker #(
    parameter int LEN_BITS = sha1e_pkg::LEN_BITS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_digest_word,
    input  logic [2:0]  i_word_index,
    input  logic        i_last_word,
    output int          o_fail_count,
    output int          o_pending
);

    import sha1e_pkg::*;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        fin;
    } t_digest_beat;

    t_digest_beat digest_q[$];

    logic [31:0] chain_h [CHAIN_WORDS];
    logic [31:0] blk_w [BLK_WORDS];
    logic [63:0] msg_bytes;
    logic [5:0]  blk_fill;
    int          fails = 0;

    function automatic logic [31:0] rol(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    task automatic restart_digest();
        chain_h[0] = IV_0;
        chain_h[1] = IV_1;
        chain_h[2] = IV_2;
        chain_h[3] = IV_3;
        chain_h[4] = IV_4;
        for (int j = 0; j < BLK_WORDS; j++) blk_w[j] = '0;
        msg_bytes = '0;
        blk_fill  = '0;
    endtask

    task automatic compress_block();
        logic [31:0] w [ROUNDS];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int r = 0; r < 16; r++) w[r] = blk_w[r];
        for (int r = 16; r < ROUNDS; r++)
            w[r] = rol(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int r = 0; r < ROUNDS; r++) begin
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = K_R0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = K_R1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_R2;
            end else begin
                f = b ^ c ^ d;
                k = K_R3;
            end
            t = rol(a, 5) + f + e + k + w[r];
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endtask

    // big-endian packing; the first byte of a word overwrites it
    task automatic place_byte(input logic [7:0] b);
        int sh;
        sh = (3 - int'(blk_fill[1:0])) * 8;
        if (blk_fill[1:0] == 2'd0) begin
            blk_w[blk_fill[5:2]] = {b, 24'h000000};
        end else begin
            blk_w[blk_fill[5:2]] |= 32'(b) << sh;
        end
    endtask

    task automatic absorb_item(input logic [7:0] data, input logic bv, input logic fin);
        logic [63:0]  bit_len;
        t_digest_beat beat;
        if (bv) begin
            place_byte(data);
            msg_bytes += 64'd1;
            blk_fill  += 6'd1;
            if (blk_fill == 6'd0) compress_block();
        end
        if (fin) begin
            bit_len = msg_bytes << 3;
            if (LEN_BITS < 64) bit_len &= (64'd1 << LEN_BITS) - 64'd1;
            place_byte(PAD_BYTE);
            for (int j = int'(blk_fill[5:2]) + 1; j < BLK_WORDS; j++) blk_w[j] = '0;
            // no room for the length field: spill into an extra block
            if (blk_fill >= 6'd56) begin
                compress_block();
                for (int j = 0; j < BLK_WORDS; j++) blk_w[j] = '0;
            end
            blk_w[LEN_HI_ADDR] = bit_len[63:32];
            blk_w[LEN_LO_ADDR] = bit_len[31:0];
            compress_block();
            for (int j = 0; j < CHAIN_WORDS; j++) begin
                beat.word = chain_h[j];
                beat.idx  = 3'(j);
                beat.fin  = (3'(j) == LAST_IDX);
                digest_q.push_back(beat);
            end
            restart_digest();
        end
    endtask

    always @(posedge i_clk) begin
        t_digest_beat want;
        if (!i_rst_n) begin
            restart_digest();
            digest_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (digest_q.size() == 0) begin
                    $display("%0t: unexpected digest transaction word=%h idx=%0d last=%b",
                             $time, i_digest_word, i_word_index, i_last_word);
                    fails++;
                end else begin
                    want = digest_q.pop_front();
                    if (i_digest_word !== want.word) begin
                        $display("%0t: digest_word expected %h actual %h",
                                 $time, want.word, i_digest_word);
                        fails++;
                    end
                    if (i_word_index !== want.idx) begin
                        $display("%0t: word_index expected %0d actual %0d",
                                 $time, want.idx, i_word_index);
                        fails++;
                    end
                    if (i_last_word !== want.fin) begin
                        $display("%0t: last_word expected %b actual %b",
                                 $time, want.fin, i_last_word);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) absorb_item(i_data_byte, i_byte_valid, i_last);
        end
        o_fail_count <= fails;
        o_pending    <= digest_q.size();
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

    logic        i_clk;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte  = 8'h00;
    logic        i_byte_valid = 1'b0;
    logic        i_last       = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready  = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    int fail_count;
    int pending;
    int sent;
    int msgs;
    bit steady = 1'b0;

    sha1_hash_engine_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_byte_valid  (i_byte_valid),
        .i_last        (i_last),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    sha1_digest_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_byte_valid  (i_byte_valid),
        .i_last        (i_last),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_digest_word (o_digest_word),
        .i_word_index  (o_word_index),
        .i_last_word   (o_last_word),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // called in the step of the previous transaction, so valid is either
    // held high (no gap) or dropped once, never both
    task automatic send_item(input logic [7:0] data, input logic bv, input logic fin);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= data;
        i_byte_valid <= bv;
        i_last       <= fin;
        do @(posedge i_clk); while (!o_in_ready);
        if (bv || fin) sent++;
    endtask

    task automatic drain_digests();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic send_message(input int len);
        bit joined;
        joined = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int n = 0; n < len; n++) begin
            if ($urandom_range(0, 7) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, joined && (n == len - 1));
        end
        if (!joined) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        msgs++;
    endtask

    initial begin
        int len;
        sent = 0;
        msgs = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty message, then an item carrying nothing
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h5A, 1'b0, 1'b0);
        // byte and end of message in one transaction
        send_item(8'h00, 1'b1, 1'b1);
        drain_digests();
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h01, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h7F, 1'b1, 1'b0);
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'hAA, 1'b1, 1'b0);
        send_item(8'h55, 1'b1, 1'b1);

        while (sent < 120) begin
            steady = ($urandom_range(0, 3) == 0);
            // lengths around 56 and 64 exercise the extra padding block
            if (msgs == 0)
                len = 56;
            else if (msgs == 1)
                len = 64;
            else if ($urandom_range(0, 3) == 0)
                len = $urandom_range(50, 70);
            else
                len = $urandom_range(0, 12);
            send_message(len);
            if ($urandom_range(0, 4) == 0) drain_digests();
        end
        steady = 1'b0;

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // result side: random stall before each transaction
    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

endmodule
